// ===== hw/rtl/itp_pkg.sv =====
// Package for the infix-to-postfix converter: operator codes, token classes,
// result kinds, status codes and the character decode and precedence functions.
// No dependencies.
package itp_pkg;

	localparam int OP_W = 3;
	typedef logic [OP_W-1:0] op_code_t;

	// Operator codes as they appear on out_operator and in the stack
	localparam op_code_t OP_ADD    = 3'd0;
	localparam op_code_t OP_SUB    = 3'd1;
	localparam op_code_t OP_MUL    = 3'd2;
	localparam op_code_t OP_DIV    = 3'd3;
	localparam op_code_t OP_POW    = 3'd4;
	localparam op_code_t OP_LPAREN = 3'd5;

	// Token kinds on func
	typedef enum logic [1:0] {
		FUNC_NUM  = 2'd0,
		FUNC_CHAR = 2'd1,
		FUNC_END  = 2'd2,
		FUNC_RSVD = 2'd3
	} func_t;

	// Result kinds on out_kind
	localparam logic [1:0] KIND_NUM    = 2'd0;
	localparam logic [1:0] KIND_OP     = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	// End status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_BADOP = 2'd1;
	localparam logic [1:0] ST_UNBAL = 2'd2;
	localparam logic [1:0] ST_OVF   = 2'd3;

	// Error flag bit positions
	localparam int FLAG_BADOP = 0;
	localparam int FLAG_UNBAL = 1;
	localparam int FLAG_OVF   = 2;

	// ASCII characters
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;

	// Pop loop flavor
	typedef enum logic [1:0] {
		MODE_OP     = 2'd0,
		MODE_RPAREN = 2'd1,
		MODE_END    = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		CLS_OP  = 2'd0,
		CLS_LP  = 2'd1,
		CLS_RP  = 2'd2,
		CLS_BAD = 2'd3
	} char_class_t;

	typedef struct packed {
		char_class_t cls;
		op_code_t    code;
	} char_dec_t;

	// Decision for one popped stack entry
	typedef struct packed {
		logic emit;      // entry goes out as an operator beat
		logic consume;   // entry leaves the stack
		logic stop;      // loop ends after this entry
		logic is_lparen;
	} pop_dec_t;

	function automatic char_dec_t decode_char(input logic [7:0] ch);
		char_dec_t d;
		d.cls  = CLS_OP;
		d.code = OP_ADD;
		case (ch)
			CH_PLUS:  d.code = OP_ADD;
			CH_MINUS: d.code = OP_SUB;
			CH_STAR:  d.code = OP_MUL;
			CH_SLASH: d.code = OP_DIV;
			CH_CARET: d.code = OP_POW;
			CH_LPAR:  d.cls  = CLS_LP;
			CH_RPAR:  d.cls  = CLS_RP;
			default:  d.cls  = CLS_BAD;
		endcase
		return d;
	endfunction

	function automatic logic [1:0] prec_of(input op_code_t c);
		logic [1:0] p;
		case (c) inside
			OP_ADD, OP_SUB: p = 2'd1;
			OP_MUL, OP_DIV: p = 2'd2;
			default:        p = 2'd3;
		endcase
		return p;
	endfunction

endpackage

// ===== hw/rtl/itp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No package dependency.
module itp_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/itp_cmp.sv =====
// Precedence compare unit: decides the fate of one popped stack entry.
// Depends on itp_pkg.
module itp_cmp import itp_pkg::*; (
	input  mode_t    mode,
	input  op_code_t code,
	input  op_code_t top,
	output pop_dec_t dec
);

	logic lp;
	logic ge;

	assign lp = (top == OP_LPAREN);
	assign ge = (prec_of(top) >= prec_of(code));

	always_comb begin
		dec.is_lparen = lp;
		case (mode)
			MODE_OP: begin
				// pop while stacked precedence is greater or equal
				dec.emit    = !lp && ge;
				dec.consume = !lp && ge;
				dec.stop    = lp || !ge;
			end
			MODE_RPAREN: begin
				dec.emit    = !lp;
				dec.consume = 1'b1;
				dec.stop    = lp;
			end
			MODE_END: begin
				dec.emit    = !lp;
				dec.consume = 1'b1;
				dec.stop    = 1'b0;
			end
			default: begin
				dec.emit    = 1'b0;
				dec.consume = 1'b0;
				dec.stop    = 1'b1;
			end
		endcase
	end

endmodule

// ===== hw/rtl/infix_to_postfix_converter_core.sv =====
// Top level of the shunting-yard infix-to-postfix converter.
// Depends on itp_pkg, itp_ram (operator stack) and itp_cmp (precedence unit).
//
// Usage:
//   Input channel (in_valid/in_stall) takes one token beat: func selects a
//   number, an operator or parenthesis character in token_char, or the end of
//   the expression. Output channel (out_valid/out_stall) gives postfix beats:
//   numbers, operators and, after an end token, one status beat. last marks
//   the final beat caused by a token. A consumer drops the whole expression
//   when the status is nonzero.
// Timing:
//   A number or a left parenthesis is handled in S_IDLE alone; a number
//   appears in the output register the cycle after acceptance. Every stack
//   entry examined takes a RAM read (S_RD) and a precedence compare in the
//   shared unit (S_CHK), including the entry that ends an operator's pops;
//   an operator, a right parenthesis or an end token adds a closing state
//   (S_FIN), an end token then S_STAT for the status beat. in_stall stays
//   high while the pop sequencer runs and while the output register is full
//   and stalled.
// Reset:
//   arst_n clears the stack count, parenthesis counters, error flags, the
//   sequencer and the output valid. The stack RAM needs no clearing: only
//   entries below the count are read. A stalled output beat is held; the
//   sequencer waits on it before producing the next beat.
module infix_to_postfix_converter_core import itp_pkg::*; #(
	parameter int STACK_DEPTH = 16,
	parameter int VALUE_BITS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [31:0] number_value,
	input  logic [7:0]  token_char,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  out_kind,
	output logic [31:0] out_number,
	output logic [2:0]  out_operator,
	output logic [1:0]  status,
	output logic        last
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(STACK_DEPTH);
	localparam logic [CW-1:0] ONE_CNT  = CW'(1);
	localparam logic [63:0] VAL_MASK =
		(VALUE_BITS >= 64) ? {64{1'b1}} : ((64'd1 << VALUE_BITS) - 64'd1);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_RD   = 5'b00010,
		S_CHK  = 5'b00100,
		S_FIN  = 5'b01000,
		S_STAT = 5'b10000
	} state_t;

	state_t         state_q, state_d;
	logic [CW-1:0]  cnt_q, cnt_d;
	logic [7:0]     lcnt_q, lcnt_d;
	logic [7:0]     rcnt_q, rcnt_d;
	logic [2:0]     flags_q, flags_d;
	mode_t          mode_q, mode_d;
	op_code_t       code_q, code_d;
	logic           found_q, found_d;
	logic           pend_valid_q, pend_valid_d;
	op_code_t       pend_op_q, pend_op_d;

	logic           out_valid_q;
	logic [1:0]     out_kind_q;
	logic [31:0]    out_number_q;
	op_code_t       out_operator_q;
	logic [1:0]     status_q;
	logic           last_q;

	logic           slot_free;
	logic           accept;
	char_dec_t      dc;
	pop_dec_t       pd;
	op_code_t       top;

	logic           we;
	logic [AW-1:0]  waddr;
	op_code_t       wdata;
	logic           re;
	logic [AW-1:0]  raddr;
	logic [CW-1:0]  cnt_dec;

	logic           emit;
	logic [1:0]     emit_kind;
	logic [31:0]    emit_num;
	op_code_t       emit_op;
	logic [1:0]     emit_st;
	logic           emit_last;
	logic           unbal_all;

	// Output register is free when empty or being taken this cycle
	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = !((state_q == S_IDLE) && slot_free);
	assign accept    = in_valid && !in_stall;
	assign dc        = decode_char(token_char);

	assign cnt_dec   = cnt_q - ONE_CNT;
	assign re        = (state_q == S_RD);
	assign raddr     = cnt_dec[AW-1:0];
	assign waddr     = cnt_q[AW-1:0];
	assign unbal_all = flags_q[FLAG_UNBAL] || (lcnt_q != rcnt_q);

	itp_ram #(
		.WIDTH(OP_W),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(top)
	);

	itp_cmp u_cmp (
		.mode(mode_q),
		.code(code_q),
		.top (top),
		.dec (pd)
	);

	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		lcnt_d       = lcnt_q;
		rcnt_d       = rcnt_q;
		flags_d      = flags_q;
		mode_d       = mode_q;
		code_d       = code_q;
		found_d      = found_q;
		pend_valid_d = pend_valid_q;
		pend_op_d    = pend_op_q;
		we           = 1'b0;
		wdata        = OP_LPAREN;
		emit         = 1'b0;
		emit_kind    = KIND_OP;
		emit_num     = '0;
		emit_op      = OP_ADD;
		emit_st      = ST_OK;
		emit_last    = 1'b0;

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (func_t'(func))
						FUNC_NUM: begin
							emit      = 1'b1;
							emit_kind = KIND_NUM;
							emit_num  = number_value & VAL_MASK[31:0];
							emit_last = 1'b1;
						end
						FUNC_CHAR: begin
							case (dc.cls)
								CLS_BAD: flags_d[FLAG_BADOP] = 1'b1;
								CLS_LP: begin
									if (lcnt_q != 8'hFF) begin
										lcnt_d = lcnt_q + 8'd1;
									end
									// push a left parenthesis, drop on full stack
									if (cnt_q == FULL_CNT) begin
										flags_d[FLAG_OVF] = 1'b1;
									end else begin
										we    = 1'b1;
										wdata = OP_LPAREN;
										cnt_d = cnt_q + ONE_CNT;
									end
								end
								CLS_RP: begin
									if (rcnt_q != 8'hFF) begin
										rcnt_d = rcnt_q + 8'd1;
									end
									mode_d  = MODE_RPAREN;
									found_d = 1'b0;
									state_d = (cnt_q != '0) ? S_RD : S_FIN;
								end
								default: begin
									mode_d  = MODE_OP;
									code_d  = dc.code;
									state_d = (cnt_q != '0) ? S_RD : S_FIN;
								end
							endcase
						end
						FUNC_END: begin
							mode_d  = MODE_END;
							state_d = (cnt_q != '0) ? S_RD : S_FIN;
						end
						default: ;
					endcase
				end
			end
			S_RD: begin
				state_d = S_CHK;
			end
			S_CHK: begin
				// hold the decision while an older pending beat cannot leave
				if (!(pd.emit && pend_valid_q && !slot_free)) begin
					if (pd.emit) begin
						if (pend_valid_q) begin
							emit    = 1'b1;
							emit_op = pend_op_q;
						end
						pend_valid_d = 1'b1;
						pend_op_d    = top;
					end
					if (pd.consume) begin
						cnt_d = cnt_dec;
					end
					if (pd.is_lparen && (mode_q == MODE_END)) begin
						flags_d[FLAG_UNBAL] = 1'b1;
					end
					if (pd.is_lparen && (mode_q == MODE_RPAREN)) begin
						found_d = 1'b1;
					end
					state_d = (!pd.stop && (cnt_q != ONE_CNT)) ? S_RD : S_FIN;
				end
			end
			S_FIN: begin
				if (!pend_valid_q || slot_free) begin
					if (pend_valid_q) begin
						emit         = 1'b1;
						emit_op      = pend_op_q;
						emit_last    = (mode_q != MODE_END);
						pend_valid_d = 1'b0;
					end
					case (mode_q)
						MODE_OP: begin
							if (cnt_q == FULL_CNT) begin
								flags_d[FLAG_OVF] = 1'b1;
							end else begin
								we    = 1'b1;
								wdata = code_q;
								cnt_d = cnt_q + ONE_CNT;
							end
							state_d = S_IDLE;
						end
						MODE_RPAREN: begin
							if (!found_q) begin
								flags_d[FLAG_UNBAL] = 1'b1;
							end
							state_d = S_IDLE;
						end
						MODE_END: state_d = S_STAT;
						default:  state_d = S_IDLE;
					endcase
				end
			end
			S_STAT: begin
				if (slot_free) begin
					emit      = 1'b1;
					emit_kind = KIND_STATUS;
					emit_last = 1'b1;
					if (flags_q[FLAG_BADOP]) begin
						emit_st = ST_BADOP;
					end else if (unbal_all) begin
						emit_st = ST_UNBAL;
					end else if (flags_q[FLAG_OVF]) begin
						emit_st = ST_OVF;
					end else begin
						emit_st = ST_OK;
					end
					// drop all expression state for the next one
					cnt_d   = '0;
					lcnt_d  = '0;
					rcnt_d  = '0;
					flags_d = '0;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			lcnt_q       <= '0;
			rcnt_q       <= '0;
			flags_q      <= '0;
			mode_q       <= MODE_OP;
			found_q      <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			cnt_q        <= cnt_d;
			lcnt_q       <= lcnt_d;
			rcnt_q       <= rcnt_d;
			flags_q      <= flags_d;
			mode_q       <= mode_d;
			found_q      <= found_d;
			pend_valid_q <= pend_valid_d;
			out_valid_q  <= emit || (out_valid_q && out_stall);
		end
	end

	// Payload registers: load on a new beat, hold otherwise
	always_ff @(posedge clk) begin
		code_q    <= code_d;
		pend_op_q <= pend_op_d;
		if (emit) begin
			out_kind_q     <= emit_kind;
			out_number_q   <= emit_num;
			out_operator_q <= emit_op;
			status_q       <= emit_st;
			last_q         <= emit_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_kind     = out_kind_q;
	assign out_number   = out_number_q;
	assign out_operator = out_operator_q;
	assign status       = status_q;
	assign last         = last_q;

	// Stack count never passes the stack depth
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL_CNT)
		else $error("stack count beyond depth");

	// A read is only issued with a nonempty stack
	a_rd_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD) |-> (cnt_q != '0))
		else $error("stack read while empty");

	// No beat stays pending once the sequencer is back to idle
	a_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_valid_q)
		else $error("pending operator left behind");

	// A status beat always closes its token
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_kind == KIND_STATUS)) |-> last)
		else $error("status beat without last");

	// Expression state is cleared after the status beat is loaded
	a_stat_clear: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_STAT) && slot_free) |=>
			((cnt_q == '0) && (flags_q == '0) && (lcnt_q == '0) && (rcnt_q == '0)))
		else $error("state not cleared after status");

endmodule
